### hw/rtl/gmas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmas_pkg: shared types and constants of the gated moving-average speed block
// Beat layouts, register map and reset values.
// ----------------------------------------------------------------------------
package gmas_pkg;

  localparam int WINDOW_DEFAULT = 20;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 21;
  localparam int SPEED_W  = 16;
  localparam int SCALE_W  = 16;
  localparam int GATE_W   = 15;
  localparam int CNT_W    = 8;
  localparam int PROD_W   = SUM_W + SCALE_W + 1;
  localparam int FRAC_W   = 16;   // Q16 scale

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [15:0]      GROUND_THR_RST = 16'd1000;
  localparam logic [14:0]      SPIKE_GATE_RST = 15'd500;
  localparam logic [CNT_W-1:0] ERR_LIMIT_RST  = 8'd30;
  localparam logic [15:0]      SPEED_SCALE_RST = 16'd3020;
  localparam logic [15:0]      LOW_SPEED_RST  = 16'd1280;

  localparam logic [CNT_W-1:0] FAIL_CNT_MAX = '1;

  typedef enum logic [2:0] {
    REG_GROUND_THR  = 3'd0,
    REG_SPIKE_GATE  = 3'd1,
    REG_ERR_LIMIT   = 3'd2,
    REG_SPEED_SCALE = 3'd3,
    REG_LOW_SPEED   = 3'd4
  } cfg_reg_e_t;

  typedef struct packed {
    logic               read_ok;
    logic [15:0]        gnd_range;
    logic signed [15:0] flow_x;
    logic [15:0]        can_speed;
  } in_beat_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]   window_sum;
    logic signed [SPEED_W-1:0] flow_speed;
    logic                      error_flag;
    logic [15:0]               selected_speed;
  } out_beat_t;

endpackage : gmas_pkg
`default_nettype wire

### hw/rtl/gmas_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmas_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module gmas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 20
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : gmas_ram
`default_nettype wire

### hw/rtl/gated_moving_average_speed.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gated_moving_average_speed: moving-average speed filter with spike gate
// One beat per sensor poll in, one result beat out per poll.
// ----------------------------------------------------------------------------
// Takes one poll beat per cycle, unless a stalled result channel has filled
// every stage, and returns one result beat per poll. The result passes
// through stage 1, stage 2, stage 3 and the output register before it is offered.
// The window samples live in a WINDOW-deep RAM; its read fills the
// first stage, the running-sum update the second, the sum x scale multiply
// the third and the saturate / speed select the fourth (output register). A
// fill flag marks the ring as fully written, so entries never written read
// as zero without a clearing pass. Registers are written over the APB port
// and are read by each stage as the poll passes it, so a write also reaches
// polls in flight; write them only while no poll is in flight.
// ----------------------------------------------------------------------------
module gated_moving_average_speed #(
  parameter int WINDOW = gmas_pkg::WINDOW_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // poll channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire gmas_pkg::in_beat_t                in_data,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output gmas_pkg::out_beat_t                    out_data,
  // register port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [gmas_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [gmas_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [gmas_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                   pready
);

  import gmas_pkg::*;

  localparam int IDX_W = $clog2(WINDOW);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [15:0]        ground_thr_r;
  logic [GATE_W-1:0]  spike_gate_r;
  logic [CNT_W-1:0]   err_limit_r;
  logic [SCALE_W-1:0] speed_scale_r;
  logic [15:0]        low_speed_r;

  logic       cfg_wr;
  cfg_reg_e_t cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_e_t'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ground_thr_r  <= GROUND_THR_RST;
      spike_gate_r  <= SPIKE_GATE_RST;
      err_limit_r   <= ERR_LIMIT_RST;
      speed_scale_r <= SPEED_SCALE_RST;
      low_speed_r   <= LOW_SPEED_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_GROUND_THR:  ground_thr_r  <= pwdata[15:0];
        REG_SPIKE_GATE:  spike_gate_r  <= pwdata[GATE_W-1:0];
        REG_ERR_LIMIT:   err_limit_r   <= pwdata[CNT_W-1:0];
        REG_SPEED_SCALE: speed_scale_r <= pwdata[SCALE_W-1:0];
        REG_LOW_SPEED:   low_speed_r   <= pwdata[15:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_sel)
      REG_GROUND_THR:  prdata = CFG_DATA_W'(ground_thr_r);
      REG_SPIKE_GATE:  prdata = CFG_DATA_W'(spike_gate_r);
      REG_ERR_LIMIT:   prdata = CFG_DATA_W'(err_limit_r);
      REG_SPEED_SCALE: prdata = CFG_DATA_W'(speed_scale_r);
      REG_LOW_SPEED:   prdata = CFG_DATA_W'(low_speed_r);
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control. Each stage loads when it is empty or its contents
  // move on in the same cycle, so bubbles collapse; an output stall ripples
  // back combinationally and holds the poll side only once every stage is
  // full.
  // --------------------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic out_free, s3_free, s2_free, s1_free;
  logic in_acc, s1_move, s2_move, s3_move;

  assign out_free = !out_valid_r || !out_stall;
  assign s3_free  = !s3_valid_r || out_free;
  assign s2_free  = !s2_valid_r || s3_free;
  assign s1_free  = !s1_valid_r || s2_free;

  assign in_stall = !s1_free;
  assign in_acc   = in_valid && s1_free;
  assign s1_move  = s1_valid_r && s2_free;
  assign s2_move  = s2_valid_r && s3_free;
  assign s3_move  = s3_valid_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) s1_valid_r  <= in_acc;
      if (s2_free) s2_valid_r  <= s1_move;
      if (s3_free) s3_valid_r  <= s2_move;
      if (out_free) out_valid_r <= s3_move;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0 (accept): decide whether the poll enters the window, issue the
  // ring read of the slot it replaces and step the ring pointer.
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0] ring_idx_r, ring_idx_nxt;
  logic             ring_full_r, ring_full_nxt;
  logic             enter;

  assign enter = in_data.read_ok && (in_data.gnd_range > ground_thr_r);

  always_comb begin
    ring_idx_nxt  = ring_idx_r;
    ring_full_nxt = ring_full_r;
    if (in_acc && enter) begin
      if (ring_idx_r == IDX_LAST) begin
        ring_idx_nxt  = '0;
        ring_full_nxt = 1'b1;
      end else begin
        ring_idx_nxt = ring_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_idx_r  <= '0;
      ring_full_r <= 1'b0;
    end else begin
      ring_idx_r  <= ring_idx_nxt;
      ring_full_r <= ring_full_nxt;
    end
  end

  // stage 1 payload
  logic                       s1_ok_r, s1_enter_r, s1_old_vld_r;
  logic signed [SAMPLE_W-1:0] s1_flow_r;
  logic [15:0]                s1_can_r;
  logic [IDX_W-1:0]           s1_idx_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ok_r      <= in_data.read_ok;
      s1_enter_r   <= enter;
      s1_flow_r    <= in_data.flow_x;
      s1_can_r     <= in_data.can_speed;
      s1_idx_r     <= ring_idx_r;
      s1_old_vld_r <= ring_full_r;  // slot already written once round
    end
  end

  // --------------------------------------------------------------------------
  // Ring memory. A slot is written when its poll leaves stage 1; the next
  // read of that slot waits for the pointer to wrap, so no forwarding.
  // --------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] ring_rd_data;
  logic                ring_wr;
  logic signed [SAMPLE_W-1:0] new_sample;

  gmas_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_wr),
    .wr_addr (s1_idx_r),
    .wr_data (new_sample),
    .rd_en   (in_acc),
    .rd_addr (ring_idx_r),
    .rd_data (ring_rd_data)
  );

  // --------------------------------------------------------------------------
  // Stage 1: spike gate, running-sum update and failure counter.
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0]    run_sum_r, run_sum_nxt;
  logic signed [SAMPLE_W-1:0] last_acc_r, last_acc_nxt;
  logic [CNT_W-1:0]           fail_cnt_r, fail_cnt_nxt;
  logic                       fail_flag_r, fail_flag_nxt;

  logic signed [SAMPLE_W-1:0] old_sample;
  logic signed [SAMPLE_W+1:0] diff, gate;
  logic                       gate_pass;
  logic [CNT_W-1:0]           cnt_inc;

  assign old_sample = s1_old_vld_r ? signed'(ring_rd_data) : '0;
  assign diff       = (SAMPLE_W+2)'(last_acc_r) - (SAMPLE_W+2)'(s1_flow_r);
  assign gate       = signed'((SAMPLE_W+2)'(spike_gate_r));
  assign gate_pass  = (diff < gate) && (diff > -gate);
  assign new_sample = gate_pass ? s1_flow_r : last_acc_r;
  assign ring_wr    = s1_move && s1_enter_r;
  assign cnt_inc    = (fail_cnt_r == FAIL_CNT_MAX) ? fail_cnt_r : fail_cnt_r + 1'b1;

  always_comb begin
    run_sum_nxt   = run_sum_r;
    last_acc_nxt  = last_acc_r;
    fail_cnt_nxt  = fail_cnt_r;
    fail_flag_nxt = fail_flag_r;
    if (s1_move) begin
      if (s1_ok_r) begin
        fail_cnt_nxt  = '0;
        fail_flag_nxt = 1'b0;
        if (s1_enter_r) begin
          // wraps modulo 2^SUM_W
          run_sum_nxt = run_sum_r - SUM_W'(old_sample) + SUM_W'(new_sample);
          if (gate_pass) last_acc_nxt = s1_flow_r;
        end
      end else begin
        fail_cnt_nxt  = cnt_inc;
        fail_flag_nxt = fail_flag_r || (cnt_inc > err_limit_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_sum_r   <= '0;
      last_acc_r  <= '0;
      fail_cnt_r  <= '0;
      fail_flag_r <= 1'b0;
    end else begin
      run_sum_r   <= run_sum_nxt;
      last_acc_r  <= last_acc_nxt;
      fail_cnt_r  <= fail_cnt_nxt;
      fail_flag_r <= fail_flag_nxt;
    end
  end

  // stage 2 payload: state after this poll
  logic signed [SUM_W-1:0] s2_sum_r;
  logic                    s2_flag_r;
  logic [15:0]             s2_can_r;

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_sum_r  <= run_sum_nxt;
      s2_flag_r <= fail_flag_nxt;
      s2_can_r  <= s1_can_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: sum x Q16 scale (21 x 17 signed).
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] s3_prod_r;
  logic signed [SUM_W-1:0]  s3_sum_r;
  logic                     s3_flag_r;
  logic [15:0]              s3_can_r;

  assign prod = PROD_W'(s2_sum_r) * signed'(PROD_W'({1'b0, speed_scale_r}));

  always_ff @(posedge clk) begin
    if (s2_move) begin
      s3_prod_r <= prod;
      s3_sum_r  <= s2_sum_r;
      s3_flag_r <= s2_flag_r;
      s3_can_r  <= s2_can_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: floor shift, saturate, pick the reported speed.
  // --------------------------------------------------------------------------
  localparam int SHR_W = PROD_W - FRAC_W;
  localparam logic signed [SHR_W-1:0] SPD_MAX = SHR_W'(32767);
  localparam logic signed [SHR_W-1:0] SPD_MIN = -SHR_W'(32768);

  logic signed [SHR_W-1:0]   shr;
  logic signed [SPEED_W-1:0] spd;
  logic [SPEED_W:0]          spd_abs;
  logic [15:0]               sel;

  assign shr = SHR_W'(s3_prod_r >>> FRAC_W);   // arithmetic shift floors

  always_comb begin
    priority if (shr > SPD_MAX) spd = SPD_MAX[SPEED_W-1:0];
    else if (shr < SPD_MIN)     spd = SPD_MIN[SPEED_W-1:0];
    else                        spd = shr[SPEED_W-1:0];
  end

  // 17 bits so that the most negative speed has a magnitude
  assign spd_abs = spd[SPEED_W-1] ? (SPEED_W+1)'(-(SPEED_W+1)'(spd))
                                  : (SPEED_W+1)'(spd);
  assign sel     = (s3_flag_r || (s3_can_r >= low_speed_r)) ? s3_can_r
                                                            : spd_abs[15:0];

  out_beat_t out_data_r;

  always_ff @(posedge clk) begin
    if (s3_move) begin
      out_data_r.window_sum     <= s3_sum_r;
      out_data_r.flow_speed     <= spd;
      out_data_r.error_flag     <= s3_flag_r;
      out_data_r.selected_speed <= sel;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule : gated_moving_average_speed
`default_nettype wire

### tb/gated_moving_average_speed_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_moving_average_speed_tb: self-checking bench for the speed filter
// Drives sensor polls and register writes, predicts every result beat and
// compares it field by field against what the block returns.
// ----------------------------------------------------------------------------
module gated_moving_average_speed_tb;
  import gmas_pkg::*;

  localparam int RING_DEPTH  = WINDOW_DEFAULT;
  localparam int STALL_LIMIT = 10000;   // cycles without any beat moving
  localparam int PHASE_POLLS = 140;
  localparam int LONG_BURST  = 260;     // enough failed polls to pin the counter
  localparam int TAIL_CYCLES = 12;      // four-stage pipe plus margin
  // addresses with no register behind them; writes must be dropped
  localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR_LO = 5'd20;
  localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR_HI = 5'd28;

  // --------------------------------------------------------------------------
  // Predictor and result store. Keeps its own copy of the window, the sum,
  // the failure counter and the registers, and queues one expected beat per
  // accepted poll.
  // --------------------------------------------------------------------------
  class speed_scoreboard;
    logic [15:0]        ground_thr;
    logic [14:0]        spike_gate;
    logic [7:0]         err_limit;
    logic [15:0]        speed_scale;
    logic [15:0]        low_limit;
    logic signed [15:0] ring [RING_DEPTH];
    int unsigned        slot;
    logic signed [20:0] win_sum;
    logic signed [15:0] last_acc;
    logic [7:0]         fail_cnt;
    logic               fail_flag;
    out_beat_t          expected_q [$];
    int unsigned        mismatches, polls, checked, entries, rejects;
    int unsigned        flagged, saturated, flow_picks;

    function void reset_state();
      ground_thr  = GROUND_THR_RST;
      spike_gate  = SPIKE_GATE_RST;
      err_limit   = ERR_LIMIT_RST;
      speed_scale = SPEED_SCALE_RST;
      low_limit   = LOW_SPEED_RST;
      foreach (ring[i]) ring[i] = '0;
      slot      = 0;
      win_sum   = '0;
      last_acc  = '0;
      fail_cnt  = '0;
      fail_flag = 1'b0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] v);
      case (addr[4:2])
        REG_GROUND_THR:  ground_thr  = v[15:0];
        REG_SPIKE_GATE:  spike_gate  = v[14:0];
        REG_ERR_LIMIT:   err_limit   = v[7:0];
        REG_SPEED_SCALE: speed_scale = v[15:0];
        REG_LOW_SPEED:   low_limit   = v[15:0];
        default: ;       // no register here
      endcase
    endfunction

    function void note_poll(in_beat_t b);
      out_beat_t e;
      int        diff, gate;
      longint    prod, spd, mag;
      polls++;
      if (b.read_ok) begin
        fail_flag = 1'b0;
        fail_cnt  = '0;
        if (b.gnd_range > ground_thr) begin
          diff    = int'(last_acc) - int'(b.flow_x);
          gate    = int'(spike_gate);
          win_sum = win_sum - ring[slot];
          // strict gate: a jump of exactly spike_gate is a spike
          if (diff < gate && diff > -gate) begin
            ring[slot] = b.flow_x;
            last_acc   = b.flow_x;
            entries++;
          end else begin
            ring[slot] = last_acc;
            rejects++;
          end
          win_sum = win_sum + ring[slot];
          slot    = (slot == RING_DEPTH - 1) ? 0 : slot + 1;
        end
      end else begin
        if (fail_cnt != FAIL_CNT_MAX) fail_cnt++;
        if (fail_cnt > err_limit) fail_flag = 1'b1;
      end
      // arithmetic shift gives floor division by 2^16
      prod = longint'(win_sum) * longint'(speed_scale);
      spd  = prod >>> FRAC_W;
      if (spd > 32767) begin
        spd = 32767;
        saturated++;
      end else if (spd < -32768) begin
        spd = -32768;
        saturated++;
      end
      mag = (spd < 0) ? -spd : spd;
      e.window_sum = win_sum;
      e.flow_speed = 16'(spd);
      e.error_flag = fail_flag;
      if (fail_flag || b.can_speed >= low_limit) begin
        e.selected_speed = b.can_speed;
      end else begin
        e.selected_speed = 16'(mag);
        flow_picks++;
      end
      if (fail_flag) flagged++;
      expected_q.push_back(e);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 100) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_result(out_beat_t got);
      out_beat_t e;
      if (expected_q.size() == 0) begin
        report("result beat with nothing outstanding");
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (got.window_sum !== e.window_sum)
        report($sformatf("window_sum got %0d want %0d", got.window_sum, e.window_sum));
      if (got.flow_speed !== e.flow_speed)
        report($sformatf("flow_speed got %0d want %0d", got.flow_speed, e.flow_speed));
      if (got.error_flag !== e.error_flag)
        report($sformatf("error_flag got %b want %b", got.error_flag, e.error_flag));
      if (got.selected_speed !== e.selected_speed)
        report($sformatf("selected_speed got %0d want %0d",
                         got.selected_speed, e.selected_speed));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n    = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_beat_t              in_data  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_data;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic                  quiet = 1'b0;   // suppresses idling on both sides
  int unsigned           idle_cycles = 0;
  speed_scoreboard       sb;

  gated_moving_average_speed u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side: random back-pressure, checked at the handshake edge.
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 38);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Watchdog: any beat on either channel resets the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               STALL_LIMIT, sb.expected_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // One poll beat: optional idle gap, then hold until accepted. The
  // prediction is taken in this process so the generator sees it at once.
  task send_poll(in_beat_t b);
    while (!quiet && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    sb.note_poll(b);
  endtask

  task poll(logic ok, logic [15:0] gd, logic signed [15:0] flow, logic [15:0] can);
    in_beat_t b;
    b.read_ok   = ok;
    b.gnd_range = gd;
    b.flow_x    = flow;
    b.can_speed = can;
    send_poll(b);
  endtask

  // Sender holds off until every expected result has come back.
  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready.
  task write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(addr, v);
    @(posedge clk);
  endtask

  task set_config(logic [15:0] thr, logic [14:0] gate, logic [7:0] lim,
                  logic [15:0] scale, logic [15:0] low);
    write_reg({REG_GROUND_THR,  2'b00}, {16'd0, thr});
    write_reg({REG_SPIKE_GATE,  2'b00}, {17'd0, gate});
    write_reg({REG_ERR_LIMIT,   2'b00}, {24'd0, lim});
    write_reg({REG_SPEED_SCALE, 2'b00}, {16'd0, scale});
    write_reg({REG_LOW_SPEED,   2'b00}, {16'd0, low});
  endtask

  task fail_burst(int len);
    in_beat_t b;
    for (int i = 0; i < len; i++) begin
      b.read_ok   = 1'b0;
      b.gnd_range = 16'($urandom);
      b.flow_x    = 16'($urandom);
      b.can_speed = 16'($urandom);
      send_poll(b);
    end
  endtask

  // Mostly good polls above threshold whose flow walks around the last
  // accepted sample, straddling the gate; the rest is bus errors and noise.
  function automatic in_beat_t make_poll();
    in_beat_t b;
    int       r, span, v;
    r           = $urandom_range(99);
    b.read_ok   = 1'($urandom);
    b.gnd_range = 16'($urandom);
    b.flow_x    = 16'($urandom);
    b.can_speed = 16'($urandom);
    if (r < 75) begin
      b.read_ok = 1'b1;
      if (sb.ground_thr != 16'hFFFF && $urandom_range(99) < 88)
        b.gnd_range = 16'($urandom_range(65535, int'(sb.ground_thr) + 1));
      span = int'(sb.spike_gate) + int'(sb.spike_gate) / 4 + 2;
      v    = int'(sb.last_acc) + $urandom_range(2 * span) - span;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      b.flow_x = 16'(v);
      if (sb.low_limit != 0 && $urandom_range(1) == 1)
        b.can_speed = 16'($urandom_range(int'(sb.low_limit) - 1, 0));
    end else if (r < 85) begin
      b.read_ok = 1'b0;
    end
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    sb = new;
    sb.reset_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset register values: threshold edge, gate edge, extremes.
    poll(1'b1, 16'd0,     16'sd0,      16'd0);      // below threshold, no entry
    poll(1'b1, 16'd1000,  16'sd100,    16'd0);      // equal to threshold, no entry
    poll(1'b1, 16'd1001,  16'sd100,    16'd0);      // first entry
    poll(1'b1, 16'd65535, 16'sd499,    16'd1279);   // inside gate, can just below limit
    poll(1'b1, 16'd65535, 16'sd999,    16'd0);      // exactly one gate away: spike
    poll(1'b1, 16'd65535, 16'sd998,    16'd0);      // just inside
    poll(1'b1, 16'd65535, 16'sd32767,  16'd0);      // spike high
    poll(1'b1, 16'd65535, -16'sd32768, 16'd65535);  // spike low, can wins
    poll(1'b0, 16'd65535, -16'sd32768, 16'd0);      // bus error: window frozen
    poll(1'b0, 16'd0,     16'sd32767,  16'd65535);
    poll(1'b1, 16'd1200,  16'sd600,    16'd1280);   // can equal to limit
    drain();

    // Directed, wide gate and full scale: saturation and a one-poll flag.
    set_config(16'd0, 15'd32767, 8'd0, 16'd65535, 16'd65535);
    poll(1'b1, 16'd1,     16'sd32767,  16'd0);
    poll(1'b1, 16'd1,     16'sd32767,  16'd0);      // positive saturation
    poll(1'b1, 16'd65535, -16'sd32768, 16'd0);      // full-scale jump rejected
    poll(1'b0, 16'd0,     16'sd0,      16'd100);    // limit zero: flag at once
    poll(1'b1, 16'd1,     16'sd1,      16'd0);      // good poll clears the flag
    poll(1'b1, 16'd1,     -16'sd32766, 16'd0);      // jump equal to gate
    poll(1'b1, 16'd1,     -16'sd30000, 16'd0);
    poll(1'b1, 16'd1,     -16'sd32768, 16'd0);
    drain();

    // Random phases, each under its own register setting.
    for (int p = 1; p <= 8; p++) begin
      case (p)
        1: set_config(16'd0, 15'd32767, 8'd0, 16'd65535, 16'd65535);
        2: set_config(16'd65535, 15'd1, 8'd254, 16'd0, 16'd0);
        3: set_config(16'd200, 15'd0, 8'd255, 16'd3020, 16'd1280);
        4: set_config(GROUND_THR_RST, SPIKE_GATE_RST, ERR_LIMIT_RST,
                      SPEED_SCALE_RST, LOW_SPEED_RST);
        default: set_config(16'($urandom_range(3000)), 15'($urandom_range(4000, 1)),
                            8'($urandom_range(40)), 16'($urandom),
                            16'($urandom_range(8000)));
      endcase
      if (p == 5) begin
        write_reg(UNMAPPED_ADDR_LO, $urandom);
        write_reg(UNMAPPED_ADDR_HI, $urandom);
      end
      quiet = (p == 4);   // one phase runs flat out on both sides
      // limit 254: flag only once the counter pins; limit 255: never
      if (p == 2 || p == 3) fail_burst(LONG_BURST);
      for (int n = 0; n < PHASE_POLLS; n++) begin
        if ($urandom_range(99) == 0)
          fail_burst($urandom_range(int'(sb.err_limit) + 3, 1));
        send_poll(make_poll());
      end
      drain();
    end

    quiet = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d polls, %0d results checked, %0d window entries, %0d spikes held",
             sb.polls, sb.checked, sb.entries, sb.rejects);
    $display("%0d results with error flag, %0d saturated, %0d flow-speed selections",
             sb.flagged, sb.saturated, sb.flow_picks);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/gmas_pkg.sv
hw/rtl/gmas_ram.sv
hw/rtl/gated_moving_average_speed.sv
tb/gated_moving_average_speed_tb.sv
